// ===== hdl/utf8d_pkg.sv =====
// shared types and constants for the utf-8 to basic-plane decoder
package utf8d_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned ReasonW = 3;
  localparam int unsigned PartW   = 10;
  localparam int unsigned PendW   = 2;

  localparam logic [ReasonW-1:0] REASON_NORMAL  = 3'd0;
  localparam logic [ReasonW-1:0] REASON_NUL     = 3'd1;
  localparam logic [ReasonW-1:0] REASON_TRUNC   = 3'd2;
  localparam logic [ReasonW-1:0] REASON_BADCONT = 3'd3;
  localparam logic [ReasonW-1:0] REASON_LEAD    = 3'd4;

  // one accepted input word
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             end_of_string;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic [CodeW-1:0]   code_unit;
    logic               has_char;
    logic               done_res;
    logic [ReasonW-1:0] stop_reason;
  } res_word_t;

  // decode stage to output register
  typedef struct packed {
    logic      fire;
    logic      emit;
    res_word_t res;
  } core_ctl_t;

endpackage

// ===== hdl/utf8d_in_reg.sv =====
// input register holding one byte word ahead of the decode stage
module utf8d_in_reg
  import utf8d_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     take,
  output logic     word_valid,
  output in_word_t word
);

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  // can load when empty or when the held word leaves this cycle
  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      word_r <= in_word;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule

// ===== hdl/utf8d_core.sv =====
// decode state and the one-byte decode step
module utf8d_core
  import utf8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      word_valid,
  input  in_word_t  word,
  input  logic      out_free,
  output core_ctl_t ctl
);

  logic [PendW-1:0] pend_r, pend_nxt;
  logic [PartW-1:0] part_r, part_nxt;
  logic             halt_r, halt_nxt;
  logic             emit;
  res_word_t        res;
  logic [ByteW-1:0] b;
  logic             last;

  assign b    = word.data_byte;
  assign last = word.end_of_string;

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    halt_nxt = halt_r;
    emit     = 1'b0;
    res      = '0;
    if (halt_r) begin
      halt_nxt = !last;
    end else if (b == '0) begin
      emit            = 1'b1;
      res.done_res    = 1'b1;
      res.stop_reason = REASON_NUL;
      pend_nxt        = '0;
      part_nxt        = '0;
      halt_nxt        = !last;
    end else if (pend_r == '0) begin
      if (!b[7]) begin
        emit          = 1'b1;
        res.code_unit = {{(CodeW-ByteW){1'b0}}, b};
        res.has_char  = 1'b1;
        res.done_res  = last;
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110) begin
        if (last) begin
          // lead byte as last byte: truncated
          emit            = 1'b1;
          res.done_res    = 1'b1;
          res.stop_reason = REASON_TRUNC;
          pend_nxt        = '0;
          part_nxt        = '0;
        end else if (b[5] == 1'b0) begin
          pend_nxt = 2'd1;
          part_nxt = {5'd0, b[4:0]};
        end else begin
          pend_nxt = 2'd2;
          part_nxt = {6'd0, b[3:0]};
        end
      end else begin
        emit            = 1'b1;
        res.done_res    = 1'b1;
        res.stop_reason = REASON_LEAD;
        pend_nxt        = '0;
        part_nxt        = '0;
        halt_nxt        = !last;
      end
    end else if (b[7:6] != 2'b10) begin
      emit            = 1'b1;
      res.done_res    = 1'b1;
      res.stop_reason = REASON_BADCONT;
      pend_nxt        = '0;
      part_nxt        = '0;
      halt_nxt        = !last;
    end else if (pend_r == 2'd1) begin
      emit          = 1'b1;
      res.code_unit = {part_r, b[5:0]};
      res.has_char  = 1'b1;
      res.done_res  = last;
      pend_nxt      = '0;
      part_nxt      = '0;
    end else if (last) begin
      emit            = 1'b1;
      res.done_res    = 1'b1;
      res.stop_reason = REASON_TRUNC;
      pend_nxt        = '0;
      part_nxt        = '0;
    end else begin
      pend_nxt = pend_r - 2'd1;
      part_nxt = {part_r[PartW-7:0], b[5:0]};
    end
  end

  // words with no result never wait on the output side
  assign ctl.fire = word_valid && (out_free || !emit);
  assign ctl.emit = emit;
  assign ctl.res  = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      part_r <= '0;
      halt_r <= 1'b0;
    end else if (ctl.fire) begin
      pend_r <= pend_nxt;
      part_r <= part_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// ===== hdl/utf8d_out_reg.sv =====
// result register on the output channel
module utf8d_out_reg
  import utf8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  core_ctl_t ctl,
  input  logic      out_stall,
  output logic      out_valid,
  output logic      out_free,
  output res_word_t res
);

  logic      valid_r, valid_nxt;
  res_word_t res_r;
  logic      load;

  assign out_free  = !valid_r || !out_stall;
  assign load      = ctl.fire && ctl.emit;
  assign valid_nxt = load ? 1'b1 : (out_free ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= ctl.res;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// ===== hdl/utf8_to_bmp_decoder_top.sv =====
// top level of the utf-8 to basic-plane decoder
// Decodes a utf-8 string arriving one byte word per cycle into 16-bit code units.
// One-, two- and three-byte sequences are handled; overlong forms and surrogates
// pass unchecked. A byte word is accepted when in_valid is high and in_stall low;
// a result word leaves when out_valid is high and out_stall low. The design is an
// input register, one shallow decode step that updates the sequence state, and a
// result register, so it sustains one byte per cycle while out_stall is low. A byte
// that completes no character produces no result word and never waits on the output
// side. The first fault in a string (nul byte, bad continuation, stray continuation
// or four-byte lead) gives one final word with done_res set and the stop reason;
// later bytes of that string give nothing until end_of_string clears the halt. A
// string cut off mid-sequence ends with a truncated report. All state returns to
// zero after the last byte.
module utf8_to_bmp_decoder_top
  import utf8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   in_data_byte,
  input  logic               in_end_of_string,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CodeW-1:0]   out_code_unit,
  output logic               out_has_char,
  output logic               out_done_res,
  output logic [ReasonW-1:0] out_stop_reason
);

  in_word_t  in_word;
  in_word_t  word;
  logic      word_valid;
  logic      out_free;
  core_ctl_t ctl;
  res_word_t res;

  assign in_word.data_byte     = in_data_byte;
  assign in_word.end_of_string = in_end_of_string;

  // input register, freed when the decode step takes its word
  utf8d_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .take       (ctl.fire),
    .word_valid (word_valid),
    .word       (word)
  );

  // sequence state and decode
  utf8d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (word_valid),
    .word       (word),
    .out_free   (out_free),
    .ctl        (ctl)
  );

  // result register
  utf8d_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_free  (out_free),
    .res       (res)
  );

  assign out_code_unit   = res.code_unit;
  assign out_has_char    = res.has_char;
  assign out_done_res    = res.done_res;
  assign out_stop_reason = res.stop_reason;

endmodule

// ===== hdl/utf8d_checker.sv =====
// port-level checks for the decoder, bound to the top level
module utf8d_checker
  import utf8d_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [ByteW-1:0]   in_data_byte,
  input logic               in_end_of_string,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CodeW-1:0]   out_code_unit,
  input logic               out_has_char,
  input logic               out_done_res,
  input logic [ReasonW-1:0] out_stop_reason
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code_unit)
      && $stable(out_has_char) && $stable(out_done_res) && $stable(out_stop_reason))
    else $error("stalled result word changed");

  // a word without a character is always a final stop report
  a_nochar_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_char |-> out_done_res && out_code_unit == '0
      && out_stop_reason != REASON_NORMAL)
    else $error("result without character is not a stop report");

  // a character always carries the normal reason
  a_char_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_char |-> out_stop_reason == REASON_NORMAL)
    else $error("character word with a stop reason");

  // stop reason stays within the defined codes
  a_reason_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stop_reason == REASON_NORMAL || out_stop_reason == REASON_NUL
      || out_stop_reason == REASON_TRUNC || out_stop_reason == REASON_BADCONT
      || out_stop_reason == REASON_LEAD)
    else $error("undefined stop reason");

  // a stalled input word holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) && $stable(in_end_of_string))
    else $error("stalled input word changed");

endmodule

bind utf8_to_bmp_decoder_top utf8d_checker u_utf8d_checker (.*);
